// ----- rtl/msp_pkg.sv -----
`default_nettype none

package msp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int DATA_WIDTH_DEFAULT = 16;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 13;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POOL_MODE     = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_WIDTH   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_HEIGHT  = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHANNEL_COUNT = 8'd3;

    // Bits kept from a configuration write, per register.
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int CHAN_BITS  = 13;

    // Reset values of the dimension registers.
    localparam logic [31:0] IMG_W_RESET = 32'd1024;
    localparam logic [31:0] IMG_H_RESET = 32'd1024;
    localparam logic [31:0] CHAN_RESET  = 32'd1;

    // Row and channel dimensions saturate here.
    localparam logic [31:0] DIM_LIMIT = 32'd4096;
    localparam int ROW_WIDTH = 12;

    // Result slots of one pixel, in emission order.
    localparam int RESULT_SLOTS = 4;
    localparam int SLOT_FULL    = 0;
    localparam int SLOT_RIGHT   = 1;
    localparam int SLOT_BOTTOM  = 2;
    localparam int SLOT_CORNER  = 3;

    localparam logic POOL_STRIDE_TWO = 1'b0;
    localparam logic POOL_STRIDE_ONE = 1'b1;

    // Jobs buffered between the front end and the result sequencer.
    localparam int QUEUE_DEPTH = 4;

    // Last valid index of a dimension: zero counts as one, large values saturate.
    function automatic logic [31:0] last_index(input logic [31:0] value,
                                               input logic [31:0] limit);
        logic [31:0] result;
        if (value == 32'd0)
        begin
            result = 32'd0;
        end
        else if (value > limit)
        begin
            result = limit - 32'd1;
        end
        else
        begin
            result = value - 32'd1;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/msp_if.sv -----
`default_nettype none

interface pixel_if #(
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface pool_if #(
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEFAULT,
    parameter int COL_WIDTH  = $clog2(msp_pkg::MAX_WIDTH_DEFAULT)
);
    logic                                 valid;
    logic                                 ready;
    logic signed [DATA_WIDTH-1:0]         pooled_value;
    logic [COL_WIDTH-1:0]                 out_column;
    logic [msp_pkg::ROW_WIDTH-1:0]        out_row;
    logic [msp_pkg::ROW_WIDTH-1:0]        out_channel;
    logic                                 last_of_run;

    modport source (output valid, output pooled_value, output out_column, output out_row,
                    output out_channel, output last_of_run, input ready);
    modport sink   (input valid, input pooled_value, input out_column, input out_row,
                    input out_channel, input last_of_run, output ready);
endinterface

interface cfg_if;
    logic                                valid;
    logic                                ready;
    logic [msp_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [msp_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/max_pool_2x2_stream.sv -----
`default_nettype none

// Channel    Role    Payload
// pixel_in   sink    pixel_value (signed), raster order: column, row, channel
// pool_out   source  pooled_value, out_column, out_row, out_channel, last_of_run
// cfg        sink    index, data; 0 pool_mode, 1 image_width, 2 image_height,
//                    3 channel_count
//
// One pixel is accepted per cycle while the queue has room; results leave through a single
// output register at one per cycle while pool_out.ready is high. In stride-one mode a pixel
// at the right edge or in the last row causes up to two results and the bottom-right corner
// four. A four-job queue between the classify stage and the result sequencer absorbs the
// right-edge bursts; along the last row the queue fills and holds back the input. A result
// passes the classify stage, the queue, the job register and the output register. Reset
// clears counters and neighbor registers; the line buffer needs no clearing pass.

module max_pool_2x2_stream #(
    parameter int MAX_WIDTH  = msp_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    pixel_if.sink  pixel_in,
    cfg_if.sink    cfg,
    pool_if.source pool_out
);

    localparam int JOB_WIDTH = 4 * DATA_WIDTH + $clog2(MAX_WIDTH)
                               + 2 * msp_pkg::ROW_WIDTH + 1 + msp_pkg::RESULT_SLOTS;

    logic                 push_valid;
    logic                 push_ready;
    logic [JOB_WIDTH-1:0] push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [JOB_WIDTH-1:0] pop_data;

    msp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .JOB_WIDTH  (JOB_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_in),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    msp_queue #(
        .WIDTH (JOB_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    msp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .JOB_WIDTH  (JOB_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pool_out  (pool_out)
    );

endmodule

`default_nettype wire

// ----- rtl/msp_front.sv -----
`default_nettype none

module msp_front #(
    parameter int MAX_WIDTH  = msp_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEFAULT,
    parameter int JOB_WIDTH  = 4 * DATA_WIDTH + $clog2(MAX_WIDTH)
                               + 2 * msp_pkg::ROW_WIDTH + 1 + msp_pkg::RESULT_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pixel_if.sink                pixel_in,
    cfg_if.sink                  cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [JOB_WIDTH-1:0] push_data
);

    localparam int COL_WIDTH = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH = msp_pkg::ROW_WIDTH;
    localparam int SLOTS     = msp_pkg::RESULT_SLOTS;

    function automatic logic signed [DATA_WIDTH-1:0] smax(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b);
        return (a < b) ? b : a;
    endfunction

    // Previous-row line buffer, read-before-write at the same address.
    logic [DATA_WIDTH-1:0] line_mem [MAX_WIDTH];

    logic                 mode_reg;
    logic [COL_WIDTH-1:0] col_last_reg;
    logic [ROW_WIDTH-1:0] row_last_reg;
    logic [ROW_WIDTH-1:0] chan_last_reg;

    logic [COL_WIDTH-1:0] col_reg, col_next;
    logic [ROW_WIDTH-1:0] row_reg, row_next;
    logic [ROW_WIDTH-1:0] chan_reg, chan_next;

    logic                         s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_cur_reg;
    logic signed [DATA_WIDTH-1:0] up_reg;
    logic [COL_WIDTH-1:0]         s1_x_reg;
    logic [ROW_WIDTH-1:0]         s1_y_reg;
    logic [ROW_WIDTH-1:0]         s1_n_reg;
    logic signed [DATA_WIDTH-1:0] upper_left_reg;
    logic signed [DATA_WIDTH-1:0] left_reg;

    logic                         accept;
    logic                         cfg_write;
    logic                         restart;
    logic                         s1_done;
    logic                         last_col;
    logic                         last_row;
    logic                         x_nonzero;
    logic                         y_nonzero;
    logic [SLOTS-1:0]             mask;
    logic signed [DATA_WIDTH-1:0] max_full;
    logic signed [DATA_WIDTH-1:0] max_right;
    logic signed [DATA_WIDTH-1:0] max_bottom;

    assign cfg.ready      = 1'b1;
    assign cfg_write      = cfg.valid;
    assign restart        = cfg_write && (cfg.index == msp_pkg::CFG_POOL_MODE
                                       || cfg.index == msp_pkg::CFG_IMAGE_WIDTH
                                       || cfg.index == msp_pkg::CFG_IMAGE_HEIGHT
                                       || cfg.index == msp_pkg::CFG_CHANNEL_COUNT);
    assign s1_done        = s1_valid_reg && (mask == '0 || push_ready);
    assign pixel_in.ready = !s1_valid_reg || s1_done;
    assign accept         = pixel_in.valid && pixel_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= msp_pkg::POOL_STRIDE_TWO;
            col_last_reg  <= COL_WIDTH'(msp_pkg::last_index(msp_pkg::IMG_W_RESET,
                                                            32'(MAX_WIDTH)));
            row_last_reg  <= ROW_WIDTH'(msp_pkg::last_index(msp_pkg::IMG_H_RESET,
                                                            msp_pkg::DIM_LIMIT));
            chan_last_reg <= ROW_WIDTH'(msp_pkg::last_index(msp_pkg::CHAN_RESET,
                                                            msp_pkg::DIM_LIMIT));
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                msp_pkg::CFG_POOL_MODE:
                begin
                    mode_reg <= cfg.data[0];
                end
                msp_pkg::CFG_IMAGE_WIDTH:
                begin
                    col_last_reg <= COL_WIDTH'(msp_pkg::last_index(
                        32'(cfg.data[msp_pkg::IMG_W_BITS-1:0]), 32'(MAX_WIDTH)));
                end
                msp_pkg::CFG_IMAGE_HEIGHT:
                begin
                    row_last_reg <= ROW_WIDTH'(msp_pkg::last_index(
                        32'(cfg.data[msp_pkg::IMG_H_BITS-1:0]), msp_pkg::DIM_LIMIT));
                end
                msp_pkg::CFG_CHANNEL_COUNT:
                begin
                    chan_last_reg <= ROW_WIDTH'(msp_pkg::last_index(
                        32'(cfg.data[msp_pkg::CHAN_BITS-1:0]), msp_pkg::DIM_LIMIT));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Raster position of the next pixel to arrive.
    always_comb
    begin
        col_next  = col_reg + COL_WIDTH'(1);
        row_next  = row_reg;
        chan_next = chan_reg;
        if (col_reg == col_last_reg)
        begin
            col_next = '0;
            row_next = row_reg + ROW_WIDTH'(1);
            if (row_reg == row_last_reg)
            begin
                row_next  = '0;
                chan_next = (chan_reg == chan_last_reg) ? '0 : chan_reg + ROW_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
        end
        else if (restart)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            chan_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg             <= line_mem[col_reg];
            line_mem[col_reg]  <= pixel_in.pixel_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg <= pixel_in.pixel_value;
            s1_x_reg   <= col_reg;
            s1_y_reg   <= row_reg;
            s1_n_reg   <= chan_reg;
        end
    end

    // Neighbor registers advance when the pixel leaves the classify stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_left_reg <= '0;
            left_reg       <= '0;
        end
        else if (restart)
        begin
            upper_left_reg <= '0;
            left_reg       <= '0;
        end
        else if (s1_done)
        begin
            upper_left_reg <= up_reg;
            left_reg       <= s1_cur_reg;
        end
    end

    always_comb
    begin
        last_col   = (s1_x_reg == col_last_reg);
        last_row   = (s1_y_reg == row_last_reg);
        x_nonzero  = (s1_x_reg != '0);
        y_nonzero  = (s1_y_reg != '0);
        max_full   = smax(smax(upper_left_reg, up_reg), smax(left_reg, s1_cur_reg));
        max_right  = smax(up_reg, s1_cur_reg);
        max_bottom = smax(left_reg, s1_cur_reg);
        mask       = '0;
        if (mode_reg == msp_pkg::POOL_STRIDE_TWO)
        begin
            mask[msp_pkg::SLOT_FULL] = s1_x_reg[0] && s1_y_reg[0];
        end
        else
        begin
            mask[msp_pkg::SLOT_FULL]   = x_nonzero && y_nonzero;
            mask[msp_pkg::SLOT_RIGHT]  = last_col && y_nonzero;
            mask[msp_pkg::SLOT_BOTTOM] = last_row && x_nonzero;
            mask[msp_pkg::SLOT_CORNER] = last_col && last_row;
        end
    end

    // Pixels that produce no result are retired here without a queue slot.
    assign push_valid = s1_valid_reg && (mask != '0);
    assign push_data  = {max_full, max_right, max_bottom, s1_cur_reg,
                         s1_x_reg, s1_y_reg, s1_n_reg, mode_reg, mask};

endmodule

`default_nettype wire

// ----- rtl/msp_queue.sv -----
`default_nettype none

module msp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = msp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msp_back.sv -----
`default_nettype none

module msp_back #(
    parameter int MAX_WIDTH  = msp_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEFAULT,
    parameter int JOB_WIDTH  = 4 * DATA_WIDTH + $clog2(MAX_WIDTH)
                               + 2 * msp_pkg::ROW_WIDTH + 1 + msp_pkg::RESULT_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [JOB_WIDTH-1:0] pop_data,
    pool_if.source               pool_out
);

    localparam int COL_WIDTH = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH = msp_pkg::ROW_WIDTH;
    localparam int SLOTS     = msp_pkg::RESULT_SLOTS;

    // Field positions inside a job word.
    localparam int MASK_LO   = 0;
    localparam int MODE_BIT  = MASK_LO + SLOTS;
    localparam int N_LO      = MODE_BIT + 1;
    localparam int Y_LO      = N_LO + ROW_WIDTH;
    localparam int X_LO      = Y_LO + ROW_WIDTH;
    localparam int CUR_LO    = X_LO + COL_WIDTH;
    localparam int BOTTOM_LO = CUR_LO + DATA_WIDTH;
    localparam int RIGHT_LO  = BOTTOM_LO + DATA_WIDTH;
    localparam int FULL_LO   = RIGHT_LO + DATA_WIDTH;

    logic [JOB_WIDTH-1:0] job_reg;
    logic [SLOTS-1:0]     rem_reg;
    logic [SLOTS-1:0]     rem_after;

    logic                 out_valid_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [COL_WIDTH-1:0] column_reg;
    logic [ROW_WIDTH-1:0] row_reg;
    logic [ROW_WIDTH-1:0] channel_reg;
    logic                 last_reg;

    logic [COL_WIDTH-1:0]  job_x;
    logic [ROW_WIDTH-1:0]  job_y;
    logic [DATA_WIDTH-1:0] sel_value;
    logic [COL_WIDTH-1:0]  sel_column;
    logic [ROW_WIDTH-1:0]  sel_row;
    logic                  busy;
    logic                  out_load;
    logic                  emit;
    logic                  do_pop;

    assign job_x = job_reg[X_LO +: COL_WIDTH];
    assign job_y = job_reg[Y_LO +: ROW_WIDTH];

    // Lowest pending slot goes out first; that matches the required order.
    always_comb
    begin
        sel_value  = job_reg[CUR_LO +: DATA_WIDTH];
        sel_column = job_x;
        sel_row    = job_y;
        rem_after  = rem_reg;
        priority if (rem_reg[msp_pkg::SLOT_FULL])
        begin
            sel_value = job_reg[FULL_LO +: DATA_WIDTH];
            if (job_reg[MODE_BIT] == msp_pkg::POOL_STRIDE_TWO)
            begin
                sel_column = job_x >> 1;
                sel_row    = job_y >> 1;
            end
            else
            begin
                sel_column = job_x - COL_WIDTH'(1);
                sel_row    = job_y - ROW_WIDTH'(1);
            end
            rem_after[msp_pkg::SLOT_FULL] = 1'b0;
        end
        else if (rem_reg[msp_pkg::SLOT_RIGHT])
        begin
            sel_value = job_reg[RIGHT_LO +: DATA_WIDTH];
            sel_row   = job_y - ROW_WIDTH'(1);
            rem_after[msp_pkg::SLOT_RIGHT] = 1'b0;
        end
        else if (rem_reg[msp_pkg::SLOT_BOTTOM])
        begin
            sel_value  = job_reg[BOTTOM_LO +: DATA_WIDTH];
            sel_column = job_x - COL_WIDTH'(1);
            rem_after[msp_pkg::SLOT_BOTTOM] = 1'b0;
        end
        else if (rem_reg[msp_pkg::SLOT_CORNER])
        begin
            rem_after[msp_pkg::SLOT_CORNER] = 1'b0;
        end
        else
        begin
            rem_after = rem_reg;
        end
    end

    assign busy      = (rem_reg != '0);
    assign out_load  = !out_valid_reg || pool_out.ready;
    assign emit      = busy && out_load;
    assign pop_ready = !busy || (emit && rem_after == '0);
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                rem_reg <= pop_data[MASK_LO +: SLOTS];
            end
            else if (emit)
            begin
                rem_reg <= rem_after;
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            job_reg <= pop_data;
        end
        if (emit)
        begin
            value_reg   <= sel_value;
            column_reg  <= sel_column;
            row_reg     <= sel_row;
            channel_reg <= job_reg[N_LO +: ROW_WIDTH];
            last_reg    <= (rem_after == '0);
        end
    end

    assign pool_out.valid        = out_valid_reg;
    assign pool_out.pooled_value = value_reg;
    assign pool_out.out_column   = column_reg;
    assign pool_out.out_row      = row_reg;
    assign pool_out.out_channel  = channel_reg;
    assign pool_out.last_of_run  = last_reg;

endmodule

`default_nettype wire
